// ----- sv/mean_and_std_deviation_defines.svh -----
// Assertion helpers for the statistics block.
`ifndef MEAN_AND_STD_DEVIATION_DEFINES_SVH
`define MEAN_AND_STD_DEVIATION_DEFINES_SVH

// Checked outside reset only.
`define MSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mean_and_std_deviation: assertion failed");

// Checked at every edge, reset included.
`define MSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mean_and_std_deviation: assertion failed");

`endif

// ----- sv/msd_pkg.sv -----
package msd_pkg;

  localparam int MAX_SAMPLES = 65536;

  localparam int SMP_W  = 16;
  localparam int SQ1_W  = 2 * SMP_W;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int RT_W   = (SQ1_W + CNT_W) / 2;
  localparam int SQ_W   = 2 * RT_W;
  localparam int DVS_W  = CNT_W + 1;
  localparam int DVD_W  = SQ_W;
  localparam int ITER_W = $clog2(DVD_W + 1);
  localparam int STD_W  = 17;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sqs;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
  } msd_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } msd_q_st_t;

endpackage

// ----- sv/mean_and_std_deviation.sv -----
// Samples: one transfer per cycle; the front end stalls only when the set queue is full.
// Result path: the shared one-bit-per-cycle divider forms the mean, then the variance,
// and the two-bit-per-cycle root takes the square root of the variance.
// Results: a new set is taken only once the last result is loaded; a two-entry queue holds sets.
// Reset (rst_ni low, asynchronous): accumulators, queue, result valid and reference mean clear.
`include "mean_and_std_deviation_defines.svh"

module mean_and_std_deviation
  import msd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    reference_mean_we_i,
  input  logic signed [SMP_W-1:0] reference_mean_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SMP_W-1:0] sample_i,
  input  logic                    last_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SMP_W-1:0] mean_value_o,
  output logic [STD_W-1:0]        std_deviation_o,
  output logic [CNT_W-1:0]        sample_count_o,
  output logic                    overflow_o
);

  logic signed [SMP_W-1:0] ref_mean_q;
  msd_q_st_t               q_st;
  logic                    push;
  msd_set_t                push_data;
  logic                    pop;
  msd_set_t                pop_data;
  logic                    count_ok;
  logic                    count_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mean_q <= '0;
    end else if (reference_mean_we_i) begin
      ref_mean_q <= reference_mean_i;
    end
  end

  msd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .ref_mean_i    (ref_mean_q),
    .q_st_i        (q_st),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  msd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .st_o        (q_st)
  );

  msd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_st_i          (q_st),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mean_value_o    (mean_value_o),
    .std_deviation_o (std_deviation_o),
    .sample_count_o  (sample_count_o),
    .overflow_o      (overflow_o)
  );

  assign count_full = sample_count_o == CNT_W'(MAX_SAMPLES);
  assign count_ok   = (sample_count_o != '0) && (sample_count_o <= CNT_W'(MAX_SAMPLES));

  `MSD_ASSERT(a_stall_needs_full, in_stall_o |-> q_st.full)
  `MSD_ASSERT(a_count_range, out_valid_o |-> count_ok)
  `MSD_ASSERT(a_overflow_saturated, (out_valid_o && overflow_o) |-> count_full)
  `MSD_ASSERT(a_queue_status, !(q_st.full && q_st.empty))

endmodule

// ----- sv/msd_front.sv -----
module msd_front
  import msd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SMP_W-1:0] sample_i,
  input  logic                    last_sample_i,
  input  logic signed [SMP_W-1:0] ref_mean_i,
  input  msd_q_st_t               q_st_i,
  output logic                    push_o,
  output msd_set_t                push_data_o
);

  logic signed [SMP_W:0]   diff;
  logic signed [SMP_W:0]   diff_neg;
  logic [SMP_W-1:0]        mag;
  logic [SQ1_W-1:0]        sq;

  logic                    a_valid_q, a_valid_d;
  logic signed [SMP_W-1:0] a_s_q;
  logic [SQ1_W-1:0]        a_sq_q;
  logic                    a_last_q;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]         sqs_q, sqs_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;

  logic                    accept;
  logic                    b_ok;
  logic                    adv;
  logic                    take;
  msd_set_t                rec;

  assign diff     = {sample_i[SMP_W-1], sample_i} - {ref_mean_i[SMP_W-1], ref_mean_i};
  assign diff_neg = -diff;
  assign mag      = diff[SMP_W] ? diff_neg[SMP_W-1:0] : diff[SMP_W-1:0];
  assign sq       = mag * mag;

  assign b_ok       = !(a_last_q && q_st_i.full);
  assign adv        = a_valid_q && b_ok;
  assign in_stall_o = a_valid_q && !b_ok;
  assign accept     = in_valid_i && !in_stall_o;

  assign take = cnt_q < CNT_W'(MAX_SAMPLES);

  always_comb begin
    if (take) begin
      rec.sum = sum_q + SUM_W'(a_s_q);
      rec.sqs = sqs_q + SQ_W'(a_sq_q);
      rec.cnt = cnt_q + CNT_W'(1);
      rec.ovf = ovf_q;
    end else begin
      rec.sum = sum_q;
      rec.sqs = sqs_q;
      rec.cnt = cnt_q;
      rec.ovf = 1'b1;
    end
  end

  assign push_o      = adv && a_last_q;
  assign push_data_o = rec;

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_comb begin
    sum_d = sum_q;
    sqs_d = sqs_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (adv) begin
      if (a_last_q) begin
        sum_d = '0;
        sqs_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        sum_d = rec.sum;
        sqs_d = rec.sqs;
        cnt_d = rec.cnt;
        ovf_d = rec.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
      sum_q     <= '0;
      sqs_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      sum_q     <= sum_d;
      sqs_q     <= sqs_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      if (accept) begin
        a_last_q <= last_sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_s_q  <= sample_i;
      a_sq_q <= sq;
    end
  end

endmodule

// ----- sv/msd_queue.sv -----
module msd_queue
  import msd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  msd_set_t  push_data_i,
  input  logic      pop_i,
  output msd_set_t  pop_data_o,
  output msd_q_st_t st_o
);

  msd_set_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

  assign pop_data_o = mem_q[rd_ptr_q];
  assign st_o.full  = cnt_q == QCNT_W'(QDEPTH);
  assign st_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/msd_back.sv -----
module msd_back
  import msd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  msd_q_st_t               q_st_i,
  input  msd_set_t                pop_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SMP_W-1:0] mean_value_o,
  output logic [STD_W-1:0]        std_deviation_o,
  output logic [CNT_W-1:0]        sample_count_o,
  output logic                    overflow_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVM = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [ITER_W-1:0]       iter_q, iter_d;

  logic                    neg_q, neg_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic                    ovf_q, ovf_d;
  logic [SQ_W-1:0]         sqs_q, sqs_d;
  logic [DVD_W-1:0]        dvd_q, dvd_d;
  logic [DVS_W-1:0]        rem_q, rem_d;
  logic [DVS_W-1:0]        dvs_q, dvs_d;
  logic [SMP_W-1:0]        mean_q, mean_d;
  logic [CNT_W-1:0]        remd_q, remd_d;
  logic [SQ_W-1:0]         v_q, v_d;
  logic [RT_W-1:0]         root_q, root_d;
  logic [RT_W:0]           srem_q, srem_d;

  logic                    out_valid_q, out_valid_d;
  logic [SMP_W-1:0]        o_mean_q;
  logic [STD_W-1:0]        o_std_q;
  logic [CNT_W-1:0]        o_cnt_q;
  logic                    o_ovf_q;
  logic                    out_load;

  logic signed [SUM_W-1:0] sum_neg;
  logic [SUM_W-1:0]        sum_mag;

  logic [DVS_W:0]          div_sh;
  logic [DVS_W:0]          div_sub;
  logic                    div_ge;
  logic [DVS_W-1:0]        div_rem;
  logic [DVD_W-1:0]        div_quo;

  logic [RT_W+2:0]         sq_acc;
  logic [RT_W+2:0]         sq_trial;
  logic [RT_W+2:0]         sq_sub;
  logic                    sq_ge;

  logic                    rnd;
  logic [RT_W-1:0]         root_fin;

  assign sum_neg = -pop_data_i.sum;
  assign sum_mag = pop_data_i.sum[SUM_W-1] ? sum_neg : pop_data_i.sum;

  assign div_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge  = div_sh >= {1'b0, dvs_q};
  assign div_sub = div_sh - {1'b0, dvs_q};
  assign div_rem = div_ge ? div_sub[DVS_W-1:0] : div_sh[DVS_W-1:0];
  assign div_quo = {dvd_q[DVD_W-2:0], div_ge};

  assign sq_acc   = {srem_q, v_q[SQ_W-1 -: 2]};
  assign sq_trial = (RT_W+3)'({root_q, 2'b01});
  assign sq_ge    = sq_acc >= sq_trial;
  assign sq_sub   = sq_acc - sq_trial;

  // round up when 4*sqs >= n*(2r+1)^2, from the two remainders
  assign rnd = (srem_q > {1'b0, root_q}) ||
               ((srem_q == {1'b0, root_q}) && ({remd_q, 2'b00} >= {2'b00, n_q}));
  assign root_fin = root_q + RT_W'(rnd);

  assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == S_IDLE) && !q_st_i.empty;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    neg_d   = neg_q;
    n_d     = n_q;
    ovf_d   = ovf_q;
    sqs_d   = sqs_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    mean_d  = mean_q;
    remd_d  = remd_q;
    v_d     = v_q;
    root_d  = root_q;
    srem_d  = srem_q;
    case (state_q)
      S_IDLE: begin
        if (!q_st_i.empty) begin
          neg_d   = pop_data_i.sum[SUM_W-1];
          n_d     = pop_data_i.cnt;
          ovf_d   = pop_data_i.ovf;
          sqs_d   = pop_data_i.sqs;
          dvd_d   = DVD_W'({sum_mag, 1'b0}) + DVD_W'(pop_data_i.cnt);
          dvs_d   = {pop_data_i.cnt, 1'b0};
          rem_d   = '0;
          iter_d  = '0;
          state_d = S_DIVM;
        end
      end
      S_DIVM: begin
        dvd_d  = div_quo;
        rem_d  = div_rem;
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(DVD_W - 1)) begin
          mean_d  = neg_q ? -div_quo[SMP_W-1:0] : div_quo[SMP_W-1:0];
          dvd_d   = sqs_q;
          dvs_d   = DVS_W'(n_q);
          rem_d   = '0;
          iter_d  = '0;
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        dvd_d  = div_quo;
        rem_d  = div_rem;
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(DVD_W - 1)) begin
          v_d     = div_quo;
          remd_d  = div_rem[CNT_W-1:0];
          root_d  = '0;
          srem_d  = '0;
          iter_d  = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        v_d    = v_q << 2;
        root_d = {root_q[RT_W-2:0], sq_ge};
        srem_d = sq_ge ? sq_sub[RT_W:0] : sq_acc[RT_W:0];
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(RT_W - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    n_q    <= n_d;
    ovf_q  <= ovf_d;
    sqs_q  <= sqs_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    mean_q <= mean_d;
    remd_q <= remd_d;
    v_q    <= v_d;
    root_q <= root_d;
    srem_q <= srem_d;
    if (out_load) begin
      o_mean_q <= mean_q;
      o_std_q  <= root_fin[STD_W-1:0];
      o_cnt_q  <= n_q;
      o_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mean_value_o    = o_mean_q;
  assign std_deviation_o = o_std_q;
  assign sample_count_o  = o_cnt_q;
  assign overflow_o      = o_ovf_q;

endmodule

// ----- dv/mean_and_std_deviation_tb.sv -----
`timescale 1ns / 100ps

module mean_and_std_deviation_tb;
  import msd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 800;

  typedef struct {
    logic signed [SMP_W-1:0] mean;
    logic [STD_W-1:0]        stdev;
    logic [CNT_W-1:0]        count;
    logic                    ovf;
  } stats_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    reference_mean_we_i = 1'b0;
  logic signed [SMP_W-1:0] reference_mean_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [SMP_W-1:0] sample_i = '0;
  logic                    last_sample_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [SMP_W-1:0] mean_value_o;
  logic [STD_W-1:0]        std_deviation_o;
  logic [CNT_W-1:0]        sample_count_o;
  logic                    overflow_o;

  mean_and_std_deviation u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .reference_mean_we_i (reference_mean_we_i),
    .reference_mean_i    (reference_mean_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_i            (sample_i),
    .last_sample_i       (last_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .mean_value_o        (mean_value_o),
    .std_deviation_o     (std_deviation_o),
    .sample_count_o      (sample_count_o),
    .overflow_o          (overflow_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [SMP_W-1:0] ref_mean_model = '0;
  logic signed [SUM_W-1:0] acc_sum = '0;
  logic [SQ_W-1:0]         acc_sq = '0;
  logic [CNT_W-1:0]        acc_cnt = '0;
  logic                    acc_ovf = 1'b0;
  stats_result_t           expected_stats[$];

  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint int_sqrt(input longint v);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = longint'(1) << 18;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void predict_sample(input logic signed [SMP_W-1:0] s, input logic last);
    longint d;
    longint n;
    longint sum_l;
    longint mag;
    longint q;
    longint sq;
    longint r;
    longint odd;
    stats_result_t res;
    if (acc_cnt < CNT_W'(MAX_SAMPLES)) begin
      d = longint'(s) - longint'(ref_mean_model);
      acc_sum = acc_sum + s;
      acc_sq = acc_sq + SQ_W'(d * d);
      acc_cnt = acc_cnt + 1'b1;
    end else begin
      acc_ovf = 1'b1;
    end
    if (last) begin
      n = longint'(acc_cnt);
      sum_l = longint'(acc_sum);
      mag = (sum_l < 0) ? -sum_l : sum_l;
      q = (2 * mag + n) / (2 * n);
      sq = longint'(acc_sq);
      r = int_sqrt(sq / n);
      odd = 2 * r + 1;
      // round half up on the root
      if (4 * sq >= n * odd * odd) r = r + 1;
      res.mean = SMP_W'((sum_l < 0) ? -q : q);
      res.stdev = STD_W'(r);
      res.count = CNT_W'(n);
      res.ovf = acc_ovf;
      expected_stats.push_back(res);
      acc_sum = '0;
      acc_sq = '0;
      acc_cnt = '0;
      acc_ovf = 1'b0;
    end
  endfunction

  task automatic report_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  task automatic check_result();
    stats_result_t exp_r;
    if (expected_stats.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none actual mean %0d std %0d",
               $time, mean_value_o, std_deviation_o);
      err_count++;
    end else begin
      exp_r = expected_stats.pop_front();
      report_field("mean_value", longint'(exp_r.mean), longint'(mean_value_o));
      report_field("std_deviation", longint'(exp_r.stdev), longint'(std_deviation_o));
      report_field("sample_count", longint'(exp_r.count), longint'(sample_count_o));
      report_field("overflow", longint'(exp_r.ovf), longint'(overflow_o));
    end
  endtask

  // result side: check, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_sample_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_sample(s, last);
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample();
    int off;
    logic signed [SMP_W-1:0] s;
    off = $urandom_range(64, 0) - 32;
    case ($urandom_range(9, 0))
      0: s = 16'sh8000;
      1: s = 16'sh7fff;
      2: s = SMP_W'(ref_mean_model + off);
      default: s = SMP_W'($urandom_range(65535, 0));
    endcase
    return s;
  endfunction

  task automatic send_random_set(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // let every pending set come out, then give the block time to go idle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reference_mean(input logic signed [SMP_W-1:0] v);
    drain_results();
    reference_mean_we_i <= 1'b1;
    reference_mean_i <= v;
    @(posedge clk_i);
    reference_mean_we_i <= 1'b0;
    ref_mean_model = v;
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    // reset reference mean of zero
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    // mean ties, both signs
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    write_reference_mean(16'sh8000);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    write_reference_mean(16'sh7fff);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
  endtask

  task automatic test_random_sets(input int send_pct, input int recv_pct,
                                  input logic signed [SMP_W-1:0] ref_v, input int n_items);
    int sent;
    int len;
    write_reference_mean(ref_v);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19, 0))
        0: len = $urandom_range(200, 41);
        1, 2, 3, 4, 5: len = $urandom_range(40, 9);
        default: len = $urandom_range(8, 1);
      endcase
      send_random_set(len);
      sent += len;
    end
  endtask

  task automatic test_result_backpressure();
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) send_random_set($urandom_range(3, 1));
    // sender waits for everything before going on
    drain_results();
    send_random_set(2);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sets(0, 0, 16'sh0000, 300);
    test_random_sets(48, 0, SMP_W'($urandom_range(65535, 0)), 300);
    test_random_sets(0, 48, 16'sh8000, 300);
    test_random_sets(22, 22, 16'sh7fff, 300);
    test_result_backpressure();
    drain_results();
    if (err_count == 0 && expected_stats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
